// ===== rtl/nlcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcs_pkg
// Shared types, sizes and codes for the lambda-closure automaton stepper.
// ----------------------------------------------------------------------------
package nlcs_pkg;

  localparam int MAX_STATES  = 16;
  localparam int MAX_SYMBOLS = 16;
  localparam int STATE_W     = $clog2(MAX_STATES);
  localparam int SYM_W       = $clog2(MAX_SYMBOLS);
  localparam int CNT_W       = 5;

  typedef logic [MAX_STATES-1:0] set_t;

  typedef enum logic [1:0] {
    OP_LOAD_TRANS  = 2'd0,
    OP_LOAD_LAMBDA = 2'd1,
    OP_START       = 2'd2,
    OP_SYMBOL      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_STATES  = 2'd0,
    CFG_SYMBOLS = 2'd1,
    CFG_INIT    = 2'd2
  } cfg_idx_t;

  // Broadcast control seen by every cell of the chain
  typedef struct packed {
    logic             ld_lambda;
    logic             ld_trans;
    logic [SYM_W-1:0] wsym;
    set_t             row;
    logic             use_trans;
    logic [SYM_W-1:0] rsym;
  } cell_ctrl_t;

  // Zero acts as one, anything above the limit acts as the limit
  function automatic logic [CNT_W-1:0] count_clamp(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    if (v > lim) r = lim;
    return r;
  endfunction

endpackage

// ===== rtl/nlcs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcs_cell
// One automaton state: holds its lambda row and its transition rows, and
// ORs the selected row into the accumulator passed down the chain.
// ----------------------------------------------------------------------------
module nlcs_cell
  import nlcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic       sel,
  input  logic       gate,
  input  set_t       acc_in,
  output set_t       acc_out
);

  set_t lam_r;
  set_t trans_r [MAX_SYMBOLS];
  set_t rd_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lam_r <= '0;
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
        trans_r[k] <= '0;
      end
    end else begin
      if (sel && ctrl.ld_lambda) lam_r <= ctrl.row;
      if (sel && ctrl.ld_trans) trans_r[ctrl.wsym] <= ctrl.row;
    end
  end

  assign rd_row  = ctrl.use_trans ? trans_r[ctrl.rsym] : lam_r;
  assign acc_out = gate ? (acc_in | rd_row) : acc_in;

endmodule

// ===== rtl/nfa_lambda_closure_stepper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_lambda_closure_stepper
// Steps a nondeterministic automaton with lambda moves over a bit-set of
// active states, using a chain of per-state cells.
// ----------------------------------------------------------------------------
//  channel | ports                              | payload
//  --------+------------------------------------+-----------------------------
//  input   | in_tvalid  in_tready  in_tdata     | opcode, source, symbol, row
//  result  | out_tvalid out_tready out_tdata    | active set, empty, bad symbol
//  config  | cfg_valid  cfg_ready  cfg_index/data | register writes
//
//  Loads and bad-symbol steps go from S_ISSUE straight to S_DONE. A symbol
//  item makes one transition pass through the cell chain and a start item takes
//  the initial mask; both then make one closure pass per cycle until the set
//  stops growing (at most MAX_STATES passes). One item is in work at a time.
//  A result waits in the output register; the next item is taken meanwhile.
//  Synchronous active-low reset clears all rows, the active set and registers.
// ----------------------------------------------------------------------------
module nfa_lambda_closure_stepper
  import nlcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // opcode[1:0] source_state[5:2] symbol_index[9:6]
                                  // row_bits[25:10], zero above
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // active_set[15:0] set_empty[16] bad_symbol[17],
                                  // zero above
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_CLOS  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  op_t                op_r;
  logic [STATE_W-1:0] src_r;
  logic [SYM_W-1:0]   sym_r;
  set_t               row_r;

  set_t cur_r, cur_nxt;
  set_t active_r, active_nxt;
  set_t res_set_r, res_set_nxt;
  logic res_bad_r, res_bad_nxt;

  logic out_valid_r;
  set_t out_set_r;
  logic out_empty_r;
  logic out_bad_r;

  logic [CNT_W-1:0] ns_cfg_r, nsym_cfg_r;
  set_t             init_r;

  logic [CNT_W-1:0] ns, nsym;
  set_t             use_mask;
  logic             sym_bad, src_ok;
  cell_ctrl_t       ctrl;
  set_t             sel, gate;
  set_t             acc [MAX_STATES+1];
  set_t             chain_set, clos_set;
  logic             in_acc, out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // ---- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_cfg_r   <= CNT_W'(16);
      nsym_cfg_r <= CNT_W'(16);
      init_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STATES:  ns_cfg_r   <= cfg_data[CNT_W-1:0];
        CFG_SYMBOLS: nsym_cfg_r <= cfg_data[CNT_W-1:0];
        CFG_INIT:    init_r     <= cfg_data[MAX_STATES-1:0];
        default: ;
      endcase
    end
  end

  assign ns      = count_clamp(ns_cfg_r, CNT_W'(MAX_STATES));
  assign nsym    = count_clamp(nsym_cfg_r, CNT_W'(MAX_SYMBOLS));
  assign sym_bad = CNT_W'(sym_r) >= nsym;
  assign src_ok  = CNT_W'(src_r) < ns;

  // ---- held item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= op_t'(in_tdata[1:0]);
      src_r <= in_tdata[5:2];
      sym_r <= in_tdata[9:6];
      row_r <= in_tdata[25:10];
    end
  end

  // ---- cell chain
  always_comb begin
    ctrl.ld_lambda = (op_r == OP_LOAD_LAMBDA) && src_ok;
    ctrl.ld_trans  = (op_r == OP_LOAD_TRANS) && src_ok && !sym_bad;
    ctrl.wsym      = sym_r;
    ctrl.row       = row_r;
    ctrl.use_trans = (state_r == S_ISSUE);
    ctrl.rsym      = sym_r;
  end

  assign acc[0] = '0;

  for (genvar i = 0; i < MAX_STATES; i++) begin : g_cell
    assign use_mask[i] = CNT_W'(i) < ns;
    assign sel[i]      = (state_r == S_ISSUE) && (src_r == STATE_W'(i));
    assign gate[i]     = (state_r == S_ISSUE) ? (active_r[i] && use_mask[i]) :
                         (state_r == S_CLOS)  ? (cur_r[i] && use_mask[i]) : 1'b0;

    nlcs_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .sel     (sel[i]),
      .gate    (gate[i]),
      .acc_in  (acc[i]),
      .acc_out (acc[i+1])
    );
  end

  assign chain_set = acc[MAX_STATES] & use_mask;
  assign clos_set  = cur_r | chain_set;

  // ---- sequencer
  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    active_nxt  = active_r;
    res_set_nxt = res_set_r;
    res_bad_nxt = res_bad_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        res_set_nxt = active_r;
        res_bad_nxt = 1'b0;
        case (op_r)
          OP_LOAD_TRANS: begin
            res_bad_nxt = sym_bad;
            state_nxt   = S_DONE;
          end
          OP_LOAD_LAMBDA: state_nxt = S_DONE;
          OP_START: begin
            cur_nxt   = init_r & use_mask;
            state_nxt = S_CLOS;
          end
          OP_SYMBOL: begin
            if (sym_bad) begin
              res_bad_nxt = 1'b1;
              state_nxt   = S_DONE;
            end else begin
              cur_nxt   = chain_set;
              state_nxt = S_CLOS;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_CLOS: begin
        cur_nxt = clos_set;
        if (clos_set == cur_r) begin
          active_nxt  = cur_r;
          res_set_nxt = cur_r;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= '0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    res_set_r <= res_set_nxt;
    res_bad_r <= res_bad_nxt;
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_set_r   <= res_set_r;
      out_empty_r <= (res_set_r == '0);
      out_bad_r   <= res_bad_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_bad_r, out_empty_r, out_set_r};

`ifndef SYNTHESIS
  // closure passes only ever add states
  a_clos_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLOS) |-> ((clos_set & cur_r) == cur_r))
    else $error("closure pass dropped a state");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_r == (out_set_r == '0)))
    else $error("empty flag disagrees with result set");

  a_accept_issue: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_ISSUE))
    else $error("accepted transaction not issued");

  a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> ($stable(out_set_r) && $stable(out_bad_r)))
    else $error("waiting result overwritten");
`endif

endmodule

// ===== tb/sv/nfa_lambda_closure_stepper_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_lambda_closure_stepper_checker
// Passive monitor for the automaton stepper. It follows register writes and
// input transactions, keeps its own copy of the row tables and active set,
// queues the predicted result of every input and compares each output
// transaction against the oldest one.
// ----------------------------------------------------------------------------
module nfa_lambda_closure_stepper_checker
  import nlcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // opcode[1:0] source_state[5:2] symbol_index[9:6]
                                  // row_bits[25:10], zero above
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // active_set[15:0] set_empty[16] bad_symbol[17],
                                  // zero above
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  typedef struct packed {
    set_t active;
    logic empty;
    logic bad_sym;
  } step_result_t;

  set_t         trans_rows [MAX_STATES*MAX_SYMBOLS];
  set_t         lambda_rows[MAX_STATES];
  set_t         active_now;
  logic [4:0]   reg_states;
  logic [4:0]   reg_symbols;
  set_t         reg_init;
  step_result_t expected_q[$];

  // zero behaves as one, anything past the table size as the table size
  function automatic int in_use(logic [4:0] v, int lim);
    if (v == 5'd0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic set_t lambda_closure(set_t seed, int n);
    set_t m;
    set_t cur;
    set_t nxt;
    bit   grown;
    m = (n >= MAX_STATES) ? '1 : set_t'((32'd1 << n) - 1);
    cur = seed & m;
    grown = 1'b1;
    while (grown) begin
      nxt = cur;
      for (int s = 0; s < n; s++)
        if (cur[s]) nxt |= lambda_rows[s] & m;
      grown = (nxt != cur);
      cur = nxt;
    end
    return cur;
  endfunction

  task automatic apply_item(input logic [31:0] d);
    op_t          op;
    logic [3:0]   src;
    logic [3:0]   sym;
    set_t         row;
    set_t         m;
    set_t         nxt;
    int           ns;
    int           nsym;
    logic         bad;
    step_result_t r;
    op   = op_t'(d[1:0]);
    src  = d[5:2];
    sym  = d[9:6];
    row  = d[25:10];
    ns   = in_use(reg_states, MAX_STATES);
    nsym = in_use(reg_symbols, MAX_SYMBOLS);
    m    = (ns >= MAX_STATES) ? '1 : set_t'((32'd1 << ns) - 1);
    bad  = 1'b0;
    case (op)
      OP_LOAD_TRANS: begin
        if (int'(sym) >= nsym) bad = 1'b1;
        else if (int'(src) < ns) trans_rows[int'(src)*MAX_SYMBOLS + int'(sym)] = row;
      end
      OP_LOAD_LAMBDA: begin
        if (int'(src) < ns) lambda_rows[src] = row;
      end
      OP_START: begin
        active_now = lambda_closure(reg_init & m, ns);
      end
      OP_SYMBOL: begin
        if (int'(sym) >= nsym) begin
          bad = 1'b1;
        end else begin
          nxt = '0;
          for (int s = 0; s < ns; s++)
            if (active_now[s]) nxt |= trans_rows[s*MAX_SYMBOLS + int'(sym)] & m;
          active_now = lambda_closure(nxt, ns);
        end
      end
    endcase
    r.active  = active_now;
    r.empty   = (active_now == '0);
    r.bad_sym = bad;
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    step_result_t want;
    step_result_t got;
    if (!rst_n) begin
      foreach (trans_rows[i]) trans_rows[i] = '0;
      foreach (lambda_rows[i]) lambda_rows[i] = '0;
      active_now   = '0;
      reg_states   = 5'd16;
      reg_symbols  = 5'd16;
      reg_init     = '0;
      expected_q.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_STATES:  reg_states  = cfg_data[4:0];
          CFG_SYMBOLS: reg_symbols = cfg_data[4:0];
          CFG_INIT:    reg_init    = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) apply_item(in_tdata);
      // an output here always belongs to an earlier input, so it is at the front
      if (out_tvalid && out_tready) begin
        got.active  = out_tdata[15:0];
        got.empty   = out_tdata[16];
        got.bad_sym = out_tdata[17];
        results_seen++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transaction: set %h empty %b bad %b",
                   $time, got.active, got.empty, got.bad_sym);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.active !== want.active || got.empty !== want.empty ||
              got.bad_sym !== want.bad_sym) begin
            $display("%0t: mismatch: expected set %h empty %b bad %b, got set %h empty %b bad %b",
                     $time, want.active, want.empty, want.bad_sym,
                     got.active, got.empty, got.bad_sym);
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/sv/nfa_lambda_closure_stepper_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_lambda_closure_stepper_tb
// Drives the automaton stepper through a directed opening and then phases of
// random automata: row loads, lambda chains, run starts and symbol streams,
// with random idle cycles on both sides and register changes between phases.
// ----------------------------------------------------------------------------
module nfa_lambda_closure_stepper_tb;
  import nlcs_pkg::*;

  localparam int ITEM_GOAL   = 1200;
  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int mismatches;
  int outstanding;
  int results_seen;
  int items_sent;
  int cfg_writes;
  int phase_no;
  int cycles;
  bit idling_on;

  nfa_lambda_closure_stepper i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  nfa_lambda_closure_stepper_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (mismatches),
    .pending      (outstanding),
    .results_seen (results_seen)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= rst_n && (!idling_on || $urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, outstanding);
      $display("nfa_lambda_closure_stepper_tb: done, errors");
      $finish;
    end
  end

  function automatic set_t rand_row();
    case ($urandom_range(4))
      0:       return '0;
      1:       return set_t'(1) << $urandom_range(15);
      2:       return set_t'($urandom & $urandom);
      3:       return set_t'($urandom & $urandom & $urandom);
      default: return set_t'($urandom);
    endcase
  endfunction

  // called and left at a falling edge; valid is only touched once per step
  task automatic send_item(input op_t op, input logic [3:0] src, input logic [3:0] sym,
                           input set_t row);
    if (idling_on)
      while ($urandom_range(99) < 22) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, row, sym, src, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [4:0] st_v;
    logic [4:0] sy_v;
    set_t       init_v;
    int         ns;
    int         nsym;
    int         pick;
    logic [3:0] src;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    idling_on  = 1'b1;
    items_sent = 0;
    cfg_writes = 0;
    phase_no   = 0;
    cycles     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed opening, registers at reset values first
    send_item(OP_START, 4'd0, 4'd0, '0);          // empty initial mask
    send_item(OP_SYMBOL, 4'd0, 4'd0, '0);         // step on an empty set
    send_item(OP_LOAD_TRANS, 4'd15, 4'd15, 16'hFFFF);
    send_item(OP_LOAD_TRANS, 4'd0, 4'd0, 16'h0001);
    drain();
    write_reg(CFG_INIT, 16'h0001);
    send_item(OP_START, 4'd0, 4'd0, '0);
    send_item(OP_LOAD_LAMBDA, 4'd0, 4'd0, 16'h0002);
    send_item(OP_LOAD_LAMBDA, 4'd1, 4'd0, 16'h0004);
    send_item(OP_LOAD_LAMBDA, 4'd2, 4'd0, 16'h8000);
    send_item(OP_START, 4'd0, 4'd0, '0);          // closure pulls in 1, 2 and 15
    send_item(OP_SYMBOL, 4'd0, 4'd15, '0);        // state 15 reaches everything
    send_item(OP_SYMBOL, 4'd0, 4'd0, '0);
    drain();
    write_reg(CFG_STATES, 16'd4);
    write_reg(CFG_SYMBOLS, 16'd2);
    write_reg(CFG_INIT, 16'hFFF1);                // bits above state 3 get cut
    send_item(OP_LOAD_TRANS, 4'd1, 4'd2, 16'h0002);   // symbol out of range
    send_item(OP_LOAD_TRANS, 4'd5, 4'd1, 16'h0002);   // state out of range
    send_item(OP_LOAD_LAMBDA, 4'd4, 4'd0, 16'h000F);  // state out of range
    send_item(OP_START, 4'd0, 4'd0, '0);
    send_item(OP_SYMBOL, 4'd0, 4'd2, '0);             // bad symbol keeps the set
    send_item(OP_SYMBOL, 4'd0, 4'd1, '0);
    drain();
    write_reg(CFG_STATES, 16'd0);
    write_reg(CFG_SYMBOLS, 16'd0);
    send_item(OP_LOAD_TRANS, 4'd0, 4'd0, 16'hFFFF);
    send_item(OP_START, 4'd0, 4'd0, '0);
    send_item(OP_SYMBOL, 4'd0, 4'd0, '0);
    send_item(OP_SYMBOL, 4'd0, 4'd1, '0);
    drain();
    write_reg(CFG_STATES, 16'd31);
    write_reg(CFG_SYMBOLS, 16'd31);
    send_item(OP_START, 4'd0, 4'd0, '0);
    send_item(OP_SYMBOL, 4'd0, 4'd15, '0);

    while (items_sent < ITEM_GOAL) begin
      case (phase_no)
        0:       begin st_v = 5'd16; sy_v = 5'd16; init_v = 16'hFFFF; end
        1:       begin st_v = 5'd1;  sy_v = 5'd1;  init_v = 16'h0001; end
        2:       begin st_v = 5'd0;  sy_v = 5'd0;  init_v = 16'hFFFF; end
        3:       begin st_v = 5'd31; sy_v = 5'd31; init_v = 16'h8001; end
        4:       begin st_v = 5'd17; sy_v = 5'd20; init_v = set_t'($urandom); end
        5:       begin st_v = 5'd4;  sy_v = 5'd3;  init_v = set_t'($urandom); end
        6:       begin st_v = 5'd16; sy_v = 5'd1;  init_v = 16'h0000; end
        7:       begin st_v = 5'd2;  sy_v = 5'd16; init_v = set_t'($urandom); end
        default: begin
          st_v   = 5'($urandom_range(31));
          sy_v   = 5'($urandom_range(31));
          init_v = rand_row();
        end
      endcase
      drain();
      write_reg(CFG_STATES, {11'd0, st_v});
      write_reg(CFG_SYMBOLS, {11'd0, sy_v});
      write_reg(CFG_INIT, init_v);
      // a stretch with no idling on either side
      idling_on <= !(phase_no == 3 || phase_no == 4);
      ns   = (st_v == 0) ? 1 : ((st_v > 16) ? 16 : st_v);
      nsym = (sy_v == 0) ? 1 : ((sy_v > 16) ? 16 : sy_v);

      repeat ($urandom_range(4, 24)) begin
        if ($urandom_range(99) < 90)
          send_item(OP_LOAD_TRANS, 4'($urandom_range(ns-1)), 4'($urandom_range(nsym-1)),
                    rand_row());
        else
          send_item(OP_LOAD_TRANS, 4'($urandom), 4'($urandom), rand_row());
      end
      // every third phase lays a full lambda chain for the longest closures
      if (phase_no % 3 == 0) begin
        for (int s = 0; s < ns - 1; s++)
          send_item(OP_LOAD_LAMBDA, 4'(s), 4'($urandom), set_t'(1) << (s + 1));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          src  = ($urandom_range(99) < 90) ? 4'($urandom_range(ns-1)) : 4'($urandom);
          pick = $urandom_range(99);
          send_item(OP_LOAD_LAMBDA, src, 4'($urandom),
                    (pick < 40) ? '0 :
                    (pick < 70) ? set_t'(1) << ((int'(src) + 1) % ns) : rand_row());
        end
      end
      send_item(OP_START, 4'($urandom), 4'($urandom), rand_row());

      repeat ($urandom_range(10, 40)) begin
        pick = $urandom_range(99);
        if (pick < 84)
          send_item(OP_SYMBOL, 4'($urandom), 4'($urandom_range(nsym-1)), rand_row());
        else if (pick < 90)
          send_item(OP_SYMBOL, 4'($urandom), 4'($urandom), rand_row());
        else if (pick < 94)
          send_item(OP_START, 4'($urandom), 4'($urandom), rand_row());
        else if (pick < 97)
          send_item(OP_LOAD_TRANS, 4'($urandom_range(ns-1)), 4'($urandom_range(nsym-1)),
                    rand_row());
        else
          send_item(op_t'($urandom_range(3)), 4'($urandom), 4'($urandom), rand_row());
      end
      phase_no++;
    end

    drain();
    repeat (40) @(negedge clk);
    $display("covered %0d input items over %0d random phases, %0d register writes",
             items_sent, phase_no, cfg_writes);
    $display("%0d results checked, %0d mismatches, %0d cycles", results_seen, mismatches,
             cycles);
    if (mismatches == 0 && outstanding == 0) begin
      $display("nfa_lambda_closure_stepper_tb: done, clean");
    end else begin
      $display("nfa_lambda_closure_stepper_tb: done, errors");
    end
    $finish;
  end

endmodule
